>>> src/cps_pkg.sv
`default_nettype none

package cps_pkg;

  localparam int OFFSET_W   = 31;
  localparam int MAG_W      = 30;
  localparam int ADJUST_W   = 13;
  localparam int GAIN_W     = 20;
  localparam int TARGET_W   = 21;
  localparam int STEP_W     = 12;
  localparam int LIMIT_W    = 20;
  localparam int INTEG_W    = 48;
  localparam int ERR_W      = 32;
  localparam int STREAK_W   = 5;
  localparam int FSTEP_W    = 2;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 31'sd1000000000;
  localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = -31'sd1000000000;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0]          GAIN_P_RST   = 20'd19661;
  localparam logic [GAIN_W-1:0]          GAIN_I_RST   = 20'd524;
  localparam logic [GAIN_W-1:0]          GAIN_D_RST   = 20'd13107;
  localparam logic signed [TARGET_W-1:0] TARGET_RST   = 21'sd0;
  localparam logic [STEP_W-1:0]          MAX_STEP_RST = 12'd96;
  localparam logic [STEP_W-1:0]          MIN_STEP_RST = 12'd16;
  localparam logic [LIMIT_W-1:0]         FAST_THR_RST = 20'd1000;
  localparam logic [LIMIT_W-1:0]         JUMP_LIM_RST = 20'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_TARGET_OFFSET  = 3'd3,
    CFG_MAX_STEP       = 3'd4,
    CFG_MIN_STEP       = 3'd5,
    CFG_FAST_THRESHOLD = 3'd6,
    CFG_JUMP_LIMIT     = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic fast;
    logic step;
  } flags_t;

endpackage

`default_nettype wire

>>> src/cps_front.sv
`default_nettype none

module cps_front #(
  parameter int HISTORY_DEPTH = 10,
  parameter int STREAK_LIMIT  = 20,
  parameter int FAST_STEPS    = 3,
  localparam int SUM_W = cps_pkg::OFFSET_W + $clog2(HISTORY_DEPTH)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                adv,
  input  wire logic                                in_valid,
  input  wire logic signed [cps_pkg::OFFSET_W-1:0] x_in,
  input  wire logic [cps_pkg::LIMIT_W-1:0]         fast_threshold,
  input  wire logic [cps_pkg::LIMIT_W-1:0]         jump_limit,
  output logic                                     out_valid,
  output logic signed [SUM_W-1:0]                  sum_out,
  output cps_pkg::flags_t                          flags_out
);

  localparam logic [cps_pkg::STREAK_W-1:0] STREAK_LIM = cps_pkg::STREAK_W'(STREAK_LIMIT);
  localparam logic [cps_pkg::FSTEP_W-1:0]  FAST_LIM   = cps_pkg::FSTEP_W'(FAST_STEPS);

  logic signed [cps_pkg::OFFSET_W-1:0] hist [HISTORY_DEPTH];
  logic signed [SUM_W-1:0]             sum;
  logic                                mode_slow;
  logic [cps_pkg::STREAK_W-1:0]        large_streak;
  logic [cps_pkg::STREAK_W-1:0]        small_streak;
  logic [cps_pkg::FSTEP_W-1:0]         fast_steps;

  logic                                mode_slow_next;
  logic [cps_pkg::STREAK_W-1:0]        large_streak_next;
  logic [cps_pkg::STREAK_W-1:0]        small_streak_next;
  logic [cps_pkg::FSTEP_W-1:0]         fast_steps_next;
  logic signed [SUM_W-1:0]             sum_next;

  logic signed [cps_pkg::OFFSET_W-1:0] x_clamp;
  logic signed [cps_pkg::OFFSET_W-1:0] x_neg;
  logic [cps_pkg::MAG_W-1:0]           x_mag;
  logic signed [cps_pkg::OFFSET_W-1:0] last;
  logic signed [cps_pkg::OFFSET_W-1:0] last_neg;
  logic [cps_pkg::MAG_W-1:0]           last_mag;
  logic signed [cps_pkg::OFFSET_W-1:0] mag_diff;
  logic signed [cps_pkg::OFFSET_W-1:0] mag_diff_neg;
  logic [cps_pkg::MAG_W-1:0]           diff_mag;
  logic                                is_large;
  logic                                outlier;
  logic signed [cps_pkg::OFFSET_W-1:0] x_sel;
  logic                                fast;
  logic                                clear_hist;
  logic                                shift_hist;

  always_comb begin
    if (x_in > cps_pkg::OFFSET_MAX) begin
      x_clamp = cps_pkg::OFFSET_MAX;
    end else if (x_in < cps_pkg::OFFSET_MIN) begin
      x_clamp = cps_pkg::OFFSET_MIN;
    end else begin
      x_clamp = x_in;
    end
    x_neg = -x_clamp;
    x_mag = x_clamp[cps_pkg::OFFSET_W-1] ? x_neg[cps_pkg::MAG_W-1:0]
                                         : x_clamp[cps_pkg::MAG_W-1:0];
    is_large = x_mag > {{(cps_pkg::MAG_W-cps_pkg::LIMIT_W){1'b0}}, fast_threshold};

    last     = hist[HISTORY_DEPTH-1];
    last_neg = -last;
    last_mag = last[cps_pkg::OFFSET_W-1] ? last_neg[cps_pkg::MAG_W-1:0]
                                         : last[cps_pkg::MAG_W-1:0];
    mag_diff     = $signed({1'b0, x_mag}) - $signed({1'b0, last_mag});
    mag_diff_neg = -mag_diff;
    diff_mag = mag_diff[cps_pkg::OFFSET_W-1] ? mag_diff_neg[cps_pkg::MAG_W-1:0]
                                             : mag_diff[cps_pkg::MAG_W-1:0];
    outlier = diff_mag > {{(cps_pkg::MAG_W-cps_pkg::LIMIT_W){1'b0}}, jump_limit};
    x_sel   = outlier ? last : x_clamp;
  end

  // streaks first, then the mode they leave decides how this item is handled
  always_comb begin
    mode_slow_next  = mode_slow;
    fast_steps_next = fast_steps;
    if (is_large) begin
      large_streak_next = large_streak + 1'b1;
      small_streak_next = '0;
    end else begin
      large_streak_next = '0;
      small_streak_next = small_streak + 1'b1;
    end
    if (large_streak_next >= STREAK_LIM) begin
      mode_slow_next    = 1'b0;
      large_streak_next = '0;
    end
    if (small_streak_next >= STREAK_LIM) begin
      mode_slow_next    = 1'b1;
      small_streak_next = '0;
    end
    fast = !mode_slow_next;
    if (fast) begin
      fast_steps_next = fast_steps + 1'b1;
      if (fast_steps_next >= FAST_LIM) begin
        mode_slow_next  = 1'b1;
        fast_steps_next = '0;
      end
    end
    clear_hist = fast && is_large;
    shift_hist = !fast;
    if (clear_hist) begin
      sum_next = '0;
    end else if (shift_hist) begin
      sum_next = sum - SUM_W'(hist[0]) + SUM_W'(x_sel);
    end else begin
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      sum          <= '0;
      mode_slow    <= 1'b0;
      large_streak <= '0;
      small_streak <= '0;
      fast_steps   <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        sum          <= sum_next;
        mode_slow    <= mode_slow_next;
        large_streak <= large_streak_next;
        small_streak <= small_streak_next;
        fast_steps   <= fast_steps_next;
        if (clear_hist) begin
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist[i] <= '0;
          end
        end else if (shift_hist) begin
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist[i] <= hist[i+1];
          end
          hist[HISTORY_DEPTH-1] <= x_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_out        <= sum_next;
      flags_out.fast <= fast;
      flags_out.step <= clear_hist;
    end
  end

endmodule

`default_nettype wire

>>> src/cps_avg.sv
`default_nettype none

module cps_avg #(
  parameter int HISTORY_DEPTH = 10,
  localparam int SUM_W = cps_pkg::OFFSET_W + $clog2(HISTORY_DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire logic                           in_valid,
  input  wire logic signed [SUM_W-1:0]        sum_in,
  input  wire cps_pkg::flags_t                flags_in,
  output logic                                out_valid,
  output logic signed [cps_pkg::OFFSET_W-1:0] avg_out,
  output cps_pkg::flags_t                     flags_out
);

  // reciprocal multiply: ceil(2^K / depth) is exact for |sum| < 2^MAG_W
  localparam int RL    = $clog2(HISTORY_DEPTH);
  localparam int MAG_W = SUM_W - 1;
  localparam int K     = MAG_W + RL;
  localparam int M_W   = MAG_W + 1;
  localparam int LO_W  = MAG_W / 2;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int FULL_W = MAG_W + M_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << K) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

  logic                    sum_neg;
  logic signed [SUM_W-1:0] sum_abs;
  logic [MAG_W-1:0]        sum_mag;
  logic [HI_W+M_W-1:0]     prod_hi_next;
  logic [LO_W+M_W-1:0]     prod_lo_next;

  logic                    v_mul;
  cps_pkg::flags_t         flags_mul;
  logic                    neg_mul;
  logic [HI_W+M_W-1:0]     prod_hi;
  logic [LO_W+M_W-1:0]     prod_lo;

  logic [FULL_W-1:0]            full;
  logic [cps_pkg::MAG_W-1:0]    quot;
  logic signed [cps_pkg::OFFSET_W-1:0] avg_next;

  always_comb begin
    sum_neg      = sum_in[SUM_W-1];
    sum_abs      = sum_neg ? -sum_in : sum_in;
    sum_mag      = sum_abs[MAG_W-1:0];
    prod_hi_next = sum_mag[MAG_W-1:LO_W] * RECIP;
    prod_lo_next = sum_mag[LO_W-1:0] * RECIP;
  end

  always_comb begin
    full     = {prod_hi, {LO_W{1'b0}}} + {{HI_W{1'b0}}, prod_lo};
    quot     = full[K +: cps_pkg::MAG_W];
    avg_next = neg_mul ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_mul     <= in_valid;
      out_valid <= v_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_mul <= flags_in;
      neg_mul   <= sum_neg;
      prod_hi   <= prod_hi_next;
      prod_lo   <= prod_lo_next;
      flags_out <= flags_mul;
      avg_out   <= avg_next;
    end
  end

endmodule

`default_nettype wire

>>> src/cps_pid.sv
`default_nettype none

module cps_pid (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                adv,
  input  wire logic                                in_valid,
  input  wire logic signed [cps_pkg::OFFSET_W-1:0] avg_in,
  input  wire cps_pkg::flags_t                     flags_in,
  input  wire logic [cps_pkg::GAIN_W-1:0]          gain_p,
  input  wire logic [cps_pkg::GAIN_W-1:0]          gain_i,
  input  wire logic [cps_pkg::GAIN_W-1:0]          gain_d,
  input  wire logic signed [cps_pkg::TARGET_W-1:0] target_offset,
  input  wire logic [cps_pkg::STEP_W-1:0]          max_step,
  input  wire logic [cps_pkg::STEP_W-1:0]          min_step,
  output logic                                     out_valid,
  output logic signed [cps_pkg::ADJUST_W-1:0]      phase_adjust,
  output logic signed [cps_pkg::OFFSET_W-1:0]      smoothed_offset,
  output logic                                     fast_mode,
  output logic                                     step_request,
  output logic                                     adjust_made
);

  localparam int EW   = cps_pkg::ERR_W;
  localparam int IW   = cps_pkg::INTEG_W;
  localparam int GW   = cps_pkg::GAIN_W;
  localparam int D_W  = EW + 1;
  localparam int PP_W = GW + 1 + EW;
  localparam int PD_W = GW + 1 + D_W;
  localparam int IH_W = IW - 16;
  localparam int PH_W = GW + 1 + IH_W;
  localparam int PL_W = GW + 16;
  localparam int S_W  = PD_W + 2;
  localparam int F_W  = PH_W + 2;
  localparam int AW   = cps_pkg::ADJUST_W;

  // integrator state
  logic signed [IW-1:0] integ;
  logic signed [EW-1:0] prev_err;
  logic signed [IW-1:0] integ_next;
  logic signed [EW-1:0] prev_err_next;
  logic signed [EW-1:0] err;
  logic signed [D_W-1:0] d_err;
  logic signed [IW:0]   integ_sum;
  logic signed [IW-1:0] integ_sat;

  // error stage
  logic                 v_err;
  cps_pkg::flags_t      fl_err;
  logic signed [cps_pkg::OFFSET_W-1:0] avg_err;
  logic signed [EW-1:0] err_q;
  logic signed [D_W-1:0] d_q;
  logic signed [IW-1:0] integ_q;

  // product stage
  logic                 v_mul;
  cps_pkg::flags_t      fl_mul;
  logic signed [cps_pkg::OFFSET_W-1:0] avg_mul;
  logic signed [PP_W-1:0] pp;
  logic signed [PD_W-1:0] pd;
  logic signed [PH_W-1:0] pih;
  logic [PL_W-1:0]        pil;
  logic signed [PP_W-1:0] pp_next;
  logic signed [PD_W-1:0] pd_next;
  logic signed [PH_W-1:0] pih_next;
  logic [PL_W-1:0]        pil_next;

  // low sum stage
  logic                 v_sum;
  cps_pkg::flags_t      fl_sum;
  logic signed [cps_pkg::OFFSET_W-1:0] avg_sum;
  logic signed [S_W-1:0]  s_low;
  logic signed [PH_W-1:0] pih_sum;
  logic signed [S_W-1:0]  s_low_next;

  // floor stage
  logic                 v_flr;
  cps_pkg::flags_t      fl_flr;
  logic signed [cps_pkg::OFFSET_W-1:0] avg_flr;
  logic signed [F_W-1:0] f_floor;
  logic                  rem_nz;
  logic signed [F_W-1:0] f_floor_next;

  // clamp
  logic signed [F_W-1:0] f_trunc;
  logic signed [F_W-1:0] mx;
  logic signed [F_W-1:0] mx_neg;
  logic signed [AW-1:0]  f_small;
  logic signed [AW-1:0]  f_small_neg;
  logic [AW-1:0]         f_mag;
  logic signed [AW-1:0]  adj;

  always_comb begin
    err       = EW'(avg_in) - EW'(target_offset);
    integ_sum = (IW+1)'(integ) + (IW+1)'(err);
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_sat = integ_sum[IW] ? cps_pkg::INTEG_MIN : cps_pkg::INTEG_MAX;
    end else begin
      integ_sat = integ_sum[IW-1:0];
    end
    d_err = D_W'(err) - D_W'(prev_err);
    if (flags_in.fast) begin
      integ_next    = flags_in.step ? '0 : integ;
      prev_err_next = prev_err;
    end else begin
      integ_next    = integ_sat;
      prev_err_next = err;
    end
  end

  // integral split into a signed upper part and an unsigned low 16 bits
  always_comb begin
    pp_next  = $signed({1'b0, gain_p}) * err_q;
    pd_next  = $signed({1'b0, gain_d}) * d_q;
    pih_next = $signed({1'b0, gain_i}) * $signed(integ_q[IW-1:16]);
    pil_next = gain_i * integ_q[15:0];
  end

  always_comb begin
    s_low_next   = S_W'(pp) + S_W'(pd) + $signed({{(S_W-PL_W){1'b0}}, pil});
    f_floor_next = F_W'(pih_sum) + F_W'($signed(s_low[S_W-1:16]));
  end

  // truncate toward zero, then clamp to max_step and apply the dead band (zero in fast mode)
  always_comb begin
    f_trunc     = f_floor + F_W'(f_floor[F_W-1] && rem_nz);
    mx          = $signed({{(F_W-cps_pkg::STEP_W){1'b0}}, max_step});
    mx_neg      = -mx;
    f_small     = f_trunc[AW-1:0];
    f_small_neg = -f_small;
    f_mag       = f_trunc[F_W-1] ? f_small_neg : f_small;
    if (fl_flr.fast) begin
      adj = '0;
    end else if (f_trunc > mx) begin
      adj = AW'(mx);
    end else if (f_trunc < mx_neg) begin
      adj = AW'(mx_neg);
    end else if (f_mag < {{(AW-cps_pkg::STEP_W){1'b0}}, min_step}) begin
      adj = '0;
    end else begin
      adj = f_small;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      prev_err  <= '0;
      v_err     <= 1'b0;
      v_mul     <= 1'b0;
      v_sum     <= 1'b0;
      v_flr     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_err     <= in_valid;
      v_mul     <= v_err;
      v_sum     <= v_mul;
      v_flr     <= v_sum;
      out_valid <= v_flr;
      if (in_valid) begin
        integ    <= integ_next;
        prev_err <= prev_err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_err  <= flags_in;
      avg_err <= avg_in;
      err_q   <= err;
      d_q     <= d_err;
      integ_q <= integ_next;

      fl_mul  <= fl_err;
      avg_mul <= avg_err;
      pp      <= pp_next;
      pd      <= pd_next;
      pih     <= pih_next;
      pil     <= pil_next;

      fl_sum  <= fl_mul;
      avg_sum <= avg_mul;
      s_low   <= s_low_next;
      pih_sum <= pih;

      fl_flr  <= fl_sum;
      avg_flr <= avg_sum;
      f_floor <= f_floor_next;
      rem_nz  <= |s_low[15:0];

      phase_adjust    <= adj;
      smoothed_offset <= fl_flr.fast ? '0 : avg_flr;
      fast_mode       <= fl_flr.fast;
      step_request    <= fl_flr.step;
      adjust_made     <= adj != '0;
    end
  end

endmodule

`default_nettype wire

>>> src/clock_phase_servo.sv
// an item passes the input register, then the front, average and PID stages
// throughput: one item per cycle; state feedback closes inside single stages
// (history and running sum in the front stage, integrator in the error stage)
// the whole pipeline holds while a result waits on out_ready
// reset: synchronous, clears history, integrator, streaks and mode (fast),
// and loads the register reset values
`default_nettype none

module clock_phase_servo #(
  parameter int HISTORY_DEPTH = 10,
  parameter int STREAK_LIMIT  = 20,
  parameter int FAST_STEPS    = 3
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [cps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [cps_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [cps_pkg::OFFSET_W-1:0]   measured_offset,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [cps_pkg::ADJUST_W-1:0]        phase_adjust,
  output logic signed [cps_pkg::OFFSET_W-1:0]        smoothed_offset,
  output logic                                       fast_mode,
  output logic                                       step_request,
  output logic                                       adjust_made
);

  localparam int SUM_W = cps_pkg::OFFSET_W + $clog2(HISTORY_DEPTH);

  logic [cps_pkg::GAIN_W-1:0]          gain_p;
  logic [cps_pkg::GAIN_W-1:0]          gain_i;
  logic [cps_pkg::GAIN_W-1:0]          gain_d;
  logic signed [cps_pkg::TARGET_W-1:0] target_offset;
  logic [cps_pkg::STEP_W-1:0]          max_step;
  logic [cps_pkg::STEP_W-1:0]          min_step;
  logic [cps_pkg::LIMIT_W-1:0]         fast_threshold;
  logic [cps_pkg::LIMIT_W-1:0]         jump_limit;

  logic                                adv;
  logic                                v_in;
  logic signed [cps_pkg::OFFSET_W-1:0] x_in;

  logic                                v_front;
  logic signed [SUM_W-1:0]             sum_front;
  cps_pkg::flags_t                     fl_front;
  logic                                v_avg;
  logic signed [cps_pkg::OFFSET_W-1:0] avg;
  cps_pkg::flags_t                     fl_avg;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= cps_pkg::GAIN_P_RST;
      gain_i         <= cps_pkg::GAIN_I_RST;
      gain_d         <= cps_pkg::GAIN_D_RST;
      target_offset  <= cps_pkg::TARGET_RST;
      max_step       <= cps_pkg::MAX_STEP_RST;
      min_step       <= cps_pkg::MIN_STEP_RST;
      fast_threshold <= cps_pkg::FAST_THR_RST;
      jump_limit     <= cps_pkg::JUMP_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cps_pkg::CFG_GAIN_P:         gain_p         <= cfg_data[cps_pkg::GAIN_W-1:0];
        cps_pkg::CFG_GAIN_I:         gain_i         <= cfg_data[cps_pkg::GAIN_W-1:0];
        cps_pkg::CFG_GAIN_D:         gain_d         <= cfg_data[cps_pkg::GAIN_W-1:0];
        cps_pkg::CFG_TARGET_OFFSET:  target_offset  <= $signed(cfg_data[cps_pkg::TARGET_W-1:0]);
        cps_pkg::CFG_MAX_STEP:       max_step       <= cfg_data[cps_pkg::STEP_W-1:0];
        cps_pkg::CFG_MIN_STEP:       min_step       <= cfg_data[cps_pkg::STEP_W-1:0];
        cps_pkg::CFG_FAST_THRESHOLD: fast_threshold <= cfg_data[cps_pkg::LIMIT_W-1:0];
        cps_pkg::CFG_JUMP_LIMIT:     jump_limit     <= cfg_data[cps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (adv) begin
      v_in <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_in <= measured_offset;
    end
  end

  cps_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .STREAK_LIMIT  (STREAK_LIMIT),
    .FAST_STEPS    (FAST_STEPS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (v_in),
    .x_in           (x_in),
    .fast_threshold (fast_threshold),
    .jump_limit     (jump_limit),
    .out_valid      (v_front),
    .sum_out        (sum_front),
    .flags_out      (fl_front)
  );

  cps_avg #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_avg (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v_front),
    .sum_in    (sum_front),
    .flags_in  (fl_front),
    .out_valid (v_avg),
    .avg_out   (avg),
    .flags_out (fl_avg)
  );

  cps_pid u_pid (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (v_avg),
    .avg_in          (avg),
    .flags_in        (fl_avg),
    .gain_p          (gain_p),
    .gain_i          (gain_i),
    .gain_d          (gain_d),
    .target_offset   (target_offset),
    .max_step        (max_step),
    .min_step        (min_step),
    .out_valid       (out_valid),
    .phase_adjust    (phase_adjust),
    .smoothed_offset (smoothed_offset),
    .fast_mode       (fast_mode),
    .step_request    (step_request),
    .adjust_made     (adjust_made)
  );

  a_fast_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fast_mode |-> phase_adjust == '0 && smoothed_offset == '0)
    else $error("fast mode result carries a nonzero adjust or average");

  a_step_in_fast: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_request |-> fast_mode)
    else $error("step request outside fast mode");

  a_adjust_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> adjust_made == (phase_adjust != '0))
    else $error("adjust_made disagrees with phase_adjust");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(step_request) && $stable(smoothed_offset))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

>>> sim/clock_phase_servo_tb.sv
`timescale 1ns / 1ps

module clock_phase_servo_tb;

  localparam int     HISTORY_DEPTH = 10;
  localparam int     STREAK_LIMIT  = 20;
  localparam int     FAST_STEPS    = 3;
  localparam int     LATENCY       = 8;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     HOLD_CYCLES   = 300;
  localparam longint SAT_LIMIT     = 64'sd1000000000;
  localparam longint INTEG_HI      = 64'sd140737488355327;
  localparam longint INTEG_LO      = -INTEG_HI - 1;

  typedef struct {
    logic signed [cps_pkg::ADJUST_W-1:0] adjust;
    logic signed [cps_pkg::OFFSET_W-1:0] smoothed;
    logic                                fast;
    logic                                step;
    logic                                made;
  } servo_result_t;

  typedef enum int {BURST_CALM, BURST_LARGE, BURST_SPIKE, BURST_NOISE} burst_kind_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [cps_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [cps_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [cps_pkg::OFFSET_W-1:0] measured_offset = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [cps_pkg::ADJUST_W-1:0] phase_adjust;
  logic signed [cps_pkg::OFFSET_W-1:0] smoothed_offset;
  logic                                fast_mode;
  logic                                step_request;
  logic                                adjust_made;

  clock_phase_servo uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .measured_offset (measured_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .phase_adjust    (phase_adjust),
    .smoothed_offset (smoothed_offset),
    .fast_mode       (fast_mode),
    .step_request    (step_request),
    .adjust_made     (adjust_made)
  );

  always #10 clk = ~clk;

  // servo state mirrored in the testbench
  longint hist [HISTORY_DEPTH];
  longint integ_acc;
  longint last_error;
  bit     in_slow;
  int     large_run, small_run, fast_count;

  longint gain_p_r, gain_i_r, gain_d_r, target_r;
  longint max_step_r, min_step_r, thr_r, jump_r;

  servo_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 65;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  bit            input_offered = 1'b0;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void servo_reset_model();
    foreach (hist[i]) hist[i] = 0;
    integ_acc  = 0;
    last_error = 0;
    in_slow    = 1'b0;
    large_run  = 0;
    small_run  = 0;
    fast_count = 0;
    gain_p_r   = cps_pkg::GAIN_P_RST;
    gain_i_r   = cps_pkg::GAIN_I_RST;
    gain_d_r   = cps_pkg::GAIN_D_RST;
    target_r   = cps_pkg::TARGET_RST;
    max_step_r = cps_pkg::MAX_STEP_RST;
    min_step_r = cps_pkg::MIN_STEP_RST;
    thr_r      = cps_pkg::FAST_THR_RST;
    jump_r     = cps_pkg::JUMP_LIM_RST;
  endfunction

  function automatic void servo_write_model(cps_pkg::cfg_index_t idx,
                                            logic [cps_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cps_pkg::CFG_GAIN_P:         gain_p_r   = longint'(data[cps_pkg::GAIN_W-1:0]);
      cps_pkg::CFG_GAIN_I:         gain_i_r   = longint'(data[cps_pkg::GAIN_W-1:0]);
      cps_pkg::CFG_GAIN_D:         gain_d_r   = longint'(data[cps_pkg::GAIN_W-1:0]);
      cps_pkg::CFG_TARGET_OFFSET:  target_r   = longint'($signed(data[cps_pkg::TARGET_W-1:0]));
      cps_pkg::CFG_MAX_STEP:       max_step_r = longint'(data[cps_pkg::STEP_W-1:0]);
      cps_pkg::CFG_MIN_STEP:       min_step_r = longint'(data[cps_pkg::STEP_W-1:0]);
      cps_pkg::CFG_FAST_THRESHOLD: thr_r      = longint'(data[cps_pkg::LIMIT_W-1:0]);
      cps_pkg::CFG_JUMP_LIMIT:     jump_r     = longint'(data[cps_pkg::LIMIT_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic servo_result_t servo_predict(logic signed [cps_pkg::OFFSET_W-1:0] raw);
    servo_result_t     r;
    longint            x, newest, sum, avg, err, diff, adj;
    logic signed [95:0] acc;
    bit                is_large;
    int                i;
    x      = raw;
    adj    = 0;
    avg    = 0;
    r.fast = 1'b0;
    r.step = 1'b0;
    if (x > SAT_LIMIT) x = SAT_LIMIT;
    if (x < -SAT_LIMIT) x = -SAT_LIMIT;

    is_large = magnitude(x) > thr_r;
    if (is_large) begin
      small_run = 0;
      large_run = (large_run + 1) & 31;
    end else begin
      large_run = 0;
      small_run = (small_run + 1) & 31;
    end
    if (large_run >= STREAK_LIMIT) begin
      in_slow   = 1'b0;
      large_run = 0;
    end
    if (small_run >= STREAK_LIMIT) begin
      in_slow   = 1'b1;
      small_run = 0;
    end

    if (!in_slow) begin
      r.fast = 1'b1;
      if (is_large) begin
        r.step    = 1'b1;
        integ_acc = 0;
        foreach (hist[k]) hist[k] = 0;
      end
      fast_count = (fast_count + 1) & 3;
      if (fast_count >= FAST_STEPS) begin
        in_slow    = 1'b1;
        fast_count = 0;
      end
    end else begin
      newest = hist[HISTORY_DEPTH-1];
      // outlier falls back to the newest stored sample
      if (magnitude(magnitude(x) - magnitude(newest)) > jump_r) x = newest;
      for (i = 0; i < HISTORY_DEPTH - 1; i++) hist[i] = hist[i+1];
      hist[HISTORY_DEPTH-1] = x;
      sum = 0;
      foreach (hist[k]) sum += hist[k];
      avg = sum / HISTORY_DEPTH;

      err = avg - target_r;
      integ_acc += err;
      if (integ_acc > INTEG_HI) integ_acc = INTEG_HI;
      if (integ_acc < INTEG_LO) integ_acc = INTEG_LO;
      diff       = err - last_error;
      last_error = err;

      // exact sum of products, one truncation toward zero
      acc = 96'(gain_p_r) * 96'(err) + 96'(gain_i_r) * 96'(integ_acc)
          + 96'(gain_d_r) * 96'(diff);
      adj = longint'(acc / 96'sd65536);
      if (magnitude(adj) > max_step_r) adj = (adj > 0) ? max_step_r : -max_step_r;
      else if (magnitude(adj) < min_step_r) adj = 0;
    end

    r.adjust   = adj[cps_pkg::ADJUST_W-1:0];
    r.smoothed = avg[cps_pkg::OFFSET_W-1:0];
    r.made     = (adj != 0);
    return r;
  endfunction

  function automatic logic signed [cps_pkg::OFFSET_W-1:0] pick_offset(burst_kind_t kind);
    longint x, m;
    x = 0;
    case (kind)
      BURST_CALM: begin
        x = longint'(int'($urandom_range(2 * thr_r + 2))) - thr_r - 1;
        if ($urandom_range(3) == 0) x += target_r;
      end
      BURST_LARGE: begin
        if ($urandom_range(15) == 0) m = SAT_LIMIT - 2 + int'($urandom_range(73741825));
        else m = thr_r + 1 + int'($urandom_range(4 * thr_r + 64));
        x = $urandom_range(1) ? m : -m;
      end
      BURST_SPIKE: begin
        // aim at the outlier boundary around the newest stored sample
        m = magnitude(hist[HISTORY_DEPTH-1]) + jump_r + int'($urandom_range(2)) - 1;
        if ($urandom_range(1) == 0) m += int'($urandom_range(3 * jump_r + 10));
        x = $urandom_range(1) ? m : -m;
      end
      BURST_NOISE: x = $urandom;
      default: x = 0;
    endcase
    return x[cps_pkg::OFFSET_W-1:0];
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic send_offset(logic signed [cps_pkg::OFFSET_W-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      if (input_offered) in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    measured_offset <= value;
    input_offered   = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(servo_predict(value));
  endtask

  task automatic wait_drained();
    if (input_offered) begin
      in_valid      <= 1'b0;
      input_offered = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cps_pkg::cfg_index_t idx, logic [cps_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    servo_write_model(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(int gp, int gi, int gd, int tgt, int mx, int mn, int thr, int jmp);
    write_reg(cps_pkg::CFG_GAIN_P, cps_pkg::CFG_DATA_W'(gp));
    write_reg(cps_pkg::CFG_GAIN_I, cps_pkg::CFG_DATA_W'(gi));
    write_reg(cps_pkg::CFG_GAIN_D, cps_pkg::CFG_DATA_W'(gd));
    write_reg(cps_pkg::CFG_TARGET_OFFSET, cps_pkg::CFG_DATA_W'(tgt));
    write_reg(cps_pkg::CFG_MAX_STEP, cps_pkg::CFG_DATA_W'(mx));
    write_reg(cps_pkg::CFG_MIN_STEP, cps_pkg::CFG_DATA_W'(mn));
    write_reg(cps_pkg::CFG_FAST_THRESHOLD, cps_pkg::CFG_DATA_W'(thr));
    write_reg(cps_pkg::CFG_JUMP_LIMIT, cps_pkg::CFG_DATA_W'(jmp));
  endtask

  task automatic random_settings();
    // upper data bits are set at random to exercise register masking
    write_all($urandom, $urandom, $urandom,
              int'($urandom_range(2000000)) - 1000000,
              int'($urandom_range(4095, 1)) | (int'($urandom_range(511)) << cps_pkg::STEP_W),
              int'($urandom_range(300)), int'($urandom_range(20000)),
              int'($urandom_range(40000)));
  endtask

  task automatic random_traffic(int count);
    int          sent;
    int          len;
    int          pick;
    burst_kind_t kind;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 50) kind = BURST_CALM;
      else if (pick < 70) kind = BURST_LARGE;
      else if (pick < 90) kind = BURST_SPIKE;
      else kind = BURST_NOISE;
      // large runs near the streak limit pull the servo back into fast mode
      len = (kind == BURST_LARGE) ? $urandom_range(24, 16) : $urandom_range(30, 3);
      repeat (len) send_offset(pick_offset(kind));
      sent += len;
    end
  endtask

  task automatic test_directed_offsets();
    int pattern [] = '{0, 1073741823, -1073741824, 0, 1000, 1001, -1000, 3001, 3000,
                       -5000, 1000000000, 1000000001, -1000000000, -1000000001,
                       16, 17, -16, -1, 1, 715827882, -715827883, 12345};
    foreach (pattern[i]) send_offset(pattern[i][cps_pkg::OFFSET_W-1:0]);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_all(1048575, 1048575, 1048575, 1000000, 4095, 0, 1000000, 1000000);
    random_traffic(80);
    wait_drained();
    // dead band wider than the clamp
    write_all(0, 0, 0, -1000000, 1, 4095, 0, 0);
    random_traffic(80);
    wait_drained();
    write_all(65536, 0, 1048575, -1000000, 4095, 4095, 5000, 0);
    random_traffic(80);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    random_settings();
    random_traffic(350);
    wait_drained();
    set_idling(65, 9);
    write_all(cps_pkg::GAIN_P_RST, cps_pkg::GAIN_I_RST, cps_pkg::GAIN_D_RST,
              cps_pkg::TARGET_RST, cps_pkg::MAX_STEP_RST, cps_pkg::MIN_STEP_RST,
              cps_pkg::FAST_THR_RST, cps_pkg::JUMP_LIM_RST);
    random_traffic(300);
    wait_drained();
    set_idling(0, 0);
    random_settings();
    random_traffic(250);
    wait_drained();
  endtask

  task automatic test_input_stall();
    hold_requests <= hold_requests + 1;
    repeat (60) send_offset(pick_offset(BURST_CALM));
    wait_drained();
  endtask

  task automatic test_drain_pause();
    random_traffic(30);
    wait_drained();
    random_traffic(30);
    wait_drained();
  endtask

  // receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    servo_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("cycle %0d: result with no item pending, adjust %0d smoothed %0d",
                   cycle_count, phase_adjust, smoothed_offset);
      end else begin
        want = pending_results.pop_front();
        if (phase_adjust !== want.adjust || smoothed_offset !== want.smoothed ||
            fast_mode !== want.fast || step_request !== want.step ||
            adjust_made !== want.made) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"cycle %0d: expected adjust %0d smoothed %0d fast %0b step %0b made %0b,",
                      " got adjust %0d smoothed %0d fast %0b step %0b made %0b"},
                     cycle_count, want.adjust, want.smoothed, want.fast, want.step,
                     want.made, phase_adjust, smoothed_offset, fast_mode, step_request,
                     adjust_made);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    servo_reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(9, 65);
    test_directed_offsets();
    test_register_extremes();
    test_random_traffic();
    test_input_stall();
    test_drain_pause();

    wait_drained();
    repeat (LATENCY * 2) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
